// ===== src/xfm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xfm_pkg - crossfade mixer shared definitions
// Sample and length widths, saturation limits and default fade counter width.
// ----------------------------------------------------------------------------
package xfm_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int LEN_W         = 20;
	localparam int FADE_BITS_DEF = 20;
	// the weighted mean never exceeds 32768 in magnitude, so 17 quotient bits do
	localparam int QUOT_BITS     = 17;

	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

endpackage

// ===== src/stereo_linear_crossfade_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_linear_crossfade_mixer - linear crossfade of two stereo tracks
// Holds the fade counters, runs both channel lanes in lockstep and keeps
// an output register so a new frame may enter while a result waits.
// ----------------------------------------------------------------------------
// Flow: a weighted frame runs FADE_BITS shift-add steps, one abs step,
//   17 divide steps and a handover; a new-track-only frame skips the lanes.
// Throughput: a new frame is taken only once the last has moved to the
//   output register; the serial multiply and divide in each lane are the
//   only work units and take one frame at a time.
// Reset: fade state cleared (not fading, counters zero), no output pending.
// ----------------------------------------------------------------------------
module stereo_linear_crossfade_mixer #(
	parameter int FADE_BITS = xfm_pkg::FADE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                start_fade,
	input  logic        [xfm_pkg::LEN_W-1:0]    fade_length,
	input  logic signed [xfm_pkg::SAMPLE_W-1:0] new_left,
	input  logic signed [xfm_pkg::SAMPLE_W-1:0] new_right,
	input  logic                                new_valid,
	input  logic signed [xfm_pkg::SAMPLE_W-1:0] old_left,
	input  logic signed [xfm_pkg::SAMPLE_W-1:0] old_right,
	input  logic                                old_valid,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [xfm_pkg::SAMPLE_W-1:0] out_left,
	output logic signed [xfm_pkg::SAMPLE_W-1:0] out_right,
	output logic                                fade_active
);

	localparam int SW = xfm_pkg::SAMPLE_W;

	logic                   busy_q;
	logic                   pend_q;
	logic                   out_valid_q;
	logic                   fading_q;
	logic [FADE_BITS-1:0]   left_q;
	logic [FADE_BITS-1:0]   total_q;

	logic                   byp_q;
	logic signed [SW-1:0]   byp_l_q;
	logic signed [SW-1:0]   byp_r_q;
	logic                   fact_q;
	logic signed [SW-1:0]   out_l_q;
	logic signed [SW-1:0]   out_r_q;
	logic                   out_fa_q;

	logic                   accept_c;
	logic                   move_c;
	logic [FADE_BITS-1:0]   len_c;
	logic                   fade_c;
	logic [FADE_BITS-1:0]   r_c;
	logic [FADE_BITS-1:0]   t_c;
	logic [FADE_BITS-1:0]   left_nxt_c;
	logic                   wgt_c;
	logic [FADE_BITS-1:0]   wn_c;
	logic signed [SW-1:0]   nl_c;
	logic signed [SW-1:0]   nr_c;
	logic signed [SW-1:0]   ol_c;
	logic signed [SW-1:0]   or_c;

	logic                   done_l;
	logic                   done_r;
	logic signed [SW-1:0]   res_l;
	logic signed [SW-1:0]   res_r;

	assign in_ready = !busy_q;
	assign accept_c = in_valid && !busy_q;
	assign move_c   = pend_q && (!out_valid_q || out_ready);

	always_comb begin
		len_c      = FADE_BITS'({{(64 - xfm_pkg::LEN_W){1'b0}}, fade_length});
		fade_c     = fading_q;
		r_c        = left_q;
		t_c        = total_q;
		if (start_fade) begin
			fade_c = (len_c != '0);
			r_c    = len_c;
			t_c    = len_c;
		end
		left_nxt_c = r_c;
		wgt_c      = 1'b0;
		if (fade_c) begin
			if (r_c != '0 && t_c != '0) begin
				wgt_c      = 1'b1;
				left_nxt_c = r_c - 1'b1;
			end else begin
				fade_c = 1'b0;
			end
		end
		wn_c = t_c - r_c;
		nl_c = new_valid ? new_left  : '0;
		nr_c = new_valid ? new_right : '0;
		ol_c = old_valid ? old_left  : '0;
		or_c = old_valid ? old_right : '0;
	end

	xfm_lane #(
		.FADE_BITS (FADE_BITS)
	) u_lane_l (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept_c && wgt_c),
		.nw      (nl_c),
		.od      (ol_c),
		.wgt_new (wn_c),
		.wgt_old (r_c),
		.total   (t_c),
		.done    (done_l),
		.result  (res_l)
	);

	xfm_lane #(
		.FADE_BITS (FADE_BITS)
	) u_lane_r (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept_c && wgt_c),
		.nw      (nr_c),
		.od      (or_c),
		.wgt_new (wn_c),
		.wgt_old (r_c),
		.total   (t_c),
		.done    (done_r),
		.result  (res_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			fading_q    <= 1'b0;
			left_q      <= '0;
			total_q     <= '0;
		end else begin
			if (accept_c) begin
				busy_q   <= 1'b1;
				pend_q   <= !wgt_c;
				fading_q <= fade_c;
				left_q   <= left_nxt_c;
				total_q  <= t_c;
			end else if (move_c) begin
				busy_q <= 1'b0;
				pend_q <= 1'b0;
			end else if (done_l) begin
				pend_q <= 1'b1;
			end

			if (move_c)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_c) begin
			byp_q   <= !wgt_c;
			byp_l_q <= nl_c;
			byp_r_q <= nr_c;
			fact_q  <= fade_c;
		end
		if (move_c) begin
			out_l_q  <= byp_q ? byp_l_q : res_l;
			out_r_q  <= byp_q ? byp_r_q : res_r;
			out_fa_q <= fact_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_left    = out_l_q;
	assign out_right   = out_r_q;
	assign fade_active = out_fa_q;

	// both lanes run the same schedule
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		done_l == done_r)
		else $error("channel lanes out of step");

	// a lane finishes only for a transaction still in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_l |-> (busy_q && !pend_q))
		else $error("lane result without a pending transaction");

	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> busy_q)
		else $error("result pending while idle");

	a_left_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		fading_q |-> (left_q < total_q))
		else $error("frames left exceed fade length");

endmodule

// ===== src/xfm_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xfm_lane - one channel of the crossfade datapath
// Bit-serial shift-add of new*(T-R) + old*R, then a restoring divide by T,
// one quotient bit per cycle, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module xfm_lane #(
	parameter int FADE_BITS = xfm_pkg::FADE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [xfm_pkg::SAMPLE_W-1:0]   nw,
	input  logic signed [xfm_pkg::SAMPLE_W-1:0]   od,
	input  logic        [FADE_BITS-1:0]           wgt_new,
	input  logic        [FADE_BITS-1:0]           wgt_old,
	input  logic        [FADE_BITS-1:0]           total,
	output logic                                  done,
	output logic signed [xfm_pkg::SAMPLE_W-1:0]   result
);

	localparam int QB       = xfm_pkg::QUOT_BITS;
	localparam int ACC_W    = FADE_BITS + QB;
	localparam int STEP_MAX = (FADE_BITS > QB) ? FADE_BITS : QB;
	localparam int CNT_W    = $clog2(STEP_MAX);
	localparam int SV_W     = QB + 1;

	typedef enum logic [4:0] {
		L_IDLE = 5'b00001,
		L_MUL  = 5'b00010,
		L_ABS  = 5'b00100,
		L_DIV  = 5'b01000,
		L_FIN  = 5'b10000
	} lane_state_t;

	lane_state_t                         state_q;
	logic        [CNT_W-1:0]             cnt_q;
	logic                                done_q;

	logic signed [xfm_pkg::SAMPLE_W-1:0] nw_q;
	logic signed [xfm_pkg::SAMPLE_W-1:0] od_q;
	logic        [FADE_BITS-1:0]         wn_q;
	logic        [FADE_BITS-1:0]         wo_q;
	logic        [FADE_BITS-1:0]         tot_q;
	logic signed [ACC_W-1:0]             acc_q;
	logic                                neg_q;
	logic        [FADE_BITS-1:0]         rem_q;
	logic        [QB-1:0]                qsh_q;
	logic signed [xfm_pkg::SAMPLE_W-1:0] res_q;

	logic signed [ACC_W-1:0]             pn_c;
	logic signed [ACC_W-1:0]             po_c;
	logic        [ACC_W-1:0]             mag_c;
	logic        [FADE_BITS:0]           trial_c;
	logic        [FADE_BITS+1:0]         diff_c;
	logic                                ge_c;
	logic signed [SV_W-1:0]              sval_c;
	logic signed [xfm_pkg::SAMPLE_W-1:0] sat_c;

	always_comb begin
		pn_c    = wn_q[FADE_BITS-1] ? ACC_W'(nw_q) : '0;
		po_c    = wo_q[FADE_BITS-1] ? ACC_W'(od_q) : '0;
		mag_c   = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		trial_c = {rem_q, qsh_q[QB-1]};
		diff_c  = {1'b0, trial_c} - {2'b00, tot_q};
		ge_c    = !diff_c[FADE_BITS+1];
		sval_c  = neg_q ? -$signed({1'b0, qsh_q}) : $signed({1'b0, qsh_q});
		if (sval_c > SV_W'(xfm_pkg::SAT_MAX))
			sat_c = xfm_pkg::SAT_MAX;
		else if (sval_c < SV_W'(xfm_pkg::SAT_MIN))
			sat_c = xfm_pkg::SAT_MIN;
		else
			sat_c = sval_c[xfm_pkg::SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				L_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= L_MUL;
						cnt_q   <= CNT_W'(FADE_BITS - 1);
					end
				end
				L_MUL: begin
					if (cnt_q == '0)
						state_q <= L_ABS;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				L_ABS: begin
					state_q <= L_DIV;
					cnt_q   <= CNT_W'(QB - 1);
				end
				L_DIV: begin
					if (cnt_q == '0)
						state_q <= L_FIN;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				L_FIN: begin
					state_q <= L_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= L_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				if (start) begin
					nw_q  <= nw;
					od_q  <= od;
					wn_q  <= wgt_new;
					wo_q  <= wgt_old;
					tot_q <= total;
					acc_q <= '0;
				end
			end
			L_MUL: begin
				// MSB first: acc = 2*acc + bit_n*new + bit_o*old
				acc_q <= (acc_q <<< 1) + pn_c + po_c;
				wn_q  <= wn_q << 1;
				wo_q  <= wo_q << 1;
			end
			L_ABS: begin
				// high part is already below T, so only QB steps remain
				neg_q <= acc_q[ACC_W-1];
				rem_q <= mag_c[ACC_W-1:QB];
				qsh_q <= mag_c[QB-1:0];
			end
			L_DIV: begin
				rem_q <= ge_c ? diff_c[FADE_BITS-1:0] : trial_c[FADE_BITS-1:0];
				qsh_q <= {qsh_q[QB-2:0], ge_c};
			end
			L_FIN: begin
				res_q <= sat_c;
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
